/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers, with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// checked at every edge, reset included
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/pfc_pkg.sv */
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, constants and square lookup functions of the Playfair cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

	localparam int SQUARE_SIDE = 5;
	localparam int CODE_BITS   = 5;
	localparam int IDX_BITS    = $clog2(SQUARE_SIDE);
	localparam int CFG_BITS    = SQUARE_SIDE * CODE_BITS;
	localparam int REG_BITS    = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = QPTR_BITS + 1;

	typedef logic [CODE_BITS-1:0] code_t;
	typedef logic [IDX_BITS-1:0]  idx_t;
	typedef logic [SQUARE_SIDE-1:0][SQUARE_SIDE-1:0][CODE_BITS-1:0] square_t;
	typedef logic [1:0][CODE_BITS-1:0] code_pair_t;

	localparam code_t CODE_I       = code_t'(8);
	localparam code_t CODE_J       = code_t'(9);
	localparam code_t FILLER_RESET = code_t'(23);
	localparam code_t PAD_RESET    = code_t'(16);

	// row 4 in the high bits, column 0 of each row in its low bits
	localparam square_t SQUARE_RESET = {
		25'd27025109, 25'd21613104, 25'd16201099, 25'd10755269, 25'd4294688
	};

	typedef enum logic {
		MODE_ENCRYPT,
		MODE_DECRYPT
	} mode_t;

	typedef enum logic [REG_BITS-1:0] {
		REG_ROW0,
		REG_ROW1,
		REG_ROW2,
		REG_ROW3,
		REG_ROW4,
		REG_MODE,
		REG_FILLER,
		REG_PAD
	} reg_idx_t;

	typedef struct packed {
		square_t square;
		mode_t   mode;
		code_t   filler;
		code_t   pad;
	} cfg_t;

	// one queue entry: one or two letter pairs produced by a single input item
	typedef struct packed {
		logic  last;
		logic  two;
		code_t a0;
		code_t b0;
		code_t a1;
		code_t b1;
	} pair_job_t;

	typedef struct packed {
		idx_t row;
		idx_t col;
	} pos_t;

	function automatic code_t fold_j(code_t c);
		return (c == CODE_J) ? CODE_I : c;
	endfunction

	// first match in row-major order wins; absent code sits at row 0, col 0
	function automatic pos_t locate(square_t sq, code_t c);
		pos_t p;
		p = '0;
		for (int r = SQUARE_SIDE - 1; r >= 0; r--) begin
			for (int k = SQUARE_SIDE - 1; k >= 0; k--) begin
				if (sq[r][k] == c) begin
					p.row = idx_t'(r);
					p.col = idx_t'(k);
				end
			end
		end
		return p;
	endfunction

	function automatic idx_t wrap_step(idx_t v, logic dec);
		idx_t n;
		if (dec)
			n = (v == '0) ? idx_t'(SQUARE_SIDE - 1) : v - idx_t'(1);
		else
			n = (v == idx_t'(SQUARE_SIDE - 1)) ? '0 : v + idx_t'(1);
		return n;
	endfunction

	function automatic code_pair_t pair_cipher(square_t sq, mode_t mode, code_t a, code_t b);
		pos_t       p1;
		pos_t       p2;
		logic       dec;
		code_pair_t r;
		dec = (mode == MODE_DECRYPT);
		p1  = locate(sq, fold_j(a));
		p2  = locate(sq, fold_j(b));
		priority if (p1.col == p2.col) begin
			r[0] = sq[wrap_step(p1.row, dec)][p1.col];
			r[1] = sq[wrap_step(p2.row, dec)][p2.col];
		end else if (p1.row == p2.row) begin
			r[0] = sq[p1.row][wrap_step(p1.col, dec)];
			r[1] = sq[p2.row][wrap_step(p2.col, dec)];
		end else begin
			r[0] = sq[p1.row][p2.col];
			r[1] = sq[p2.row][p1.col];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/playfair_digraph_cipher.sv */
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// Streaming Playfair cipher over a configurable 5x5 key square.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  -------   ---------  ---------          -------
//  input     in         push / full        letter, message_end
//  result    out        pop / empty        out_letter, out_last
//  config    in         cfg_we             cfg_index, cfg_wdata
//
// An input item is taken whenever the pair queue has room; the
// front end turns it into zero, one or two letter pairs in that same cycle.
// The back end handles one produced letter at a time (stripped decrypt
// letters included, up to four per item) through its single shared
// pair-transform unit, holding a kept letter while the result is not taken.
// Results pass through the pair queue, job register and output register.
// Reset is asynchronous: queue and pair state clear, the key square, mode,
// filler and pad return to their defaults. No clearing pass is needed.
// A stalled result side fills the 4-entry queue, then full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_digraph_cipher (
	input  wire                            clk,
	input  wire                            arst_n,
	// input items
	input  wire                            push,
	output logic                           full,
	input  pfc_pkg::code_t                 letter,
	input  wire                            message_end,
	// result items
	output logic                           empty,
	input  wire                            pop,
	output pfc_pkg::code_t                 out_letter,
	output logic                           out_last,
	// configuration writes
	input  wire                            cfg_we,
	input  wire [pfc_pkg::REG_BITS-1:0]    cfg_index,
	input  wire [pfc_pkg::CFG_BITS-1:0]    cfg_wdata
);
	import pfc_pkg::*;

	cfg_t      cfg_q;

	// front -> queue -> back
	logic      fq_push;
	pair_job_t fq_job;
	logic      q_full;
	logic      q_empty;
	logic      q_pop;
	pair_job_t q_job;

	// configuration registers: user must write only while idle; block won't check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.square <= SQUARE_RESET;
			cfg_q.mode   <= MODE_ENCRYPT;
			cfg_q.filler <= FILLER_RESET;
			cfg_q.pad    <= PAD_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ROW0:   cfg_q.square[0] <= cfg_wdata;
				REG_ROW1:   cfg_q.square[1] <= cfg_wdata;
				REG_ROW2:   cfg_q.square[2] <= cfg_wdata;
				REG_ROW3:   cfg_q.square[3] <= cfg_wdata;
				REG_ROW4:   cfg_q.square[4] <= cfg_wdata;
				REG_MODE:   cfg_q.mode      <= mode_t'(cfg_wdata[0]);
				REG_FILLER: cfg_q.filler    <= cfg_wdata[CODE_BITS-1:0];
				REG_PAD:    cfg_q.pad       <= cfg_wdata[CODE_BITS-1:0];
			endcase
		end
	end

	// front end: doubled-letter filler, pairing, closing pad
	pfc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.push        (push),
		.letter      (letter),
		.message_end (message_end),
		.q_full      (q_full),
		.q_push      (fq_push),
		.q_job       (fq_job)
	);

	assign full = q_full;

	// pair queue lets the input and result sides stall independently
	pfc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.wr_job (fq_job),
		.full   (q_full),
		.pop    (q_pop),
		.rd_job (q_job),
		.empty  (q_empty)
	);

	// back end: square lookup, shift or rectangle rule, decrypt stripping
	pfc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_empty    (q_empty),
		.q_job      (q_job),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.out_letter (out_letter),
		.out_last   (out_last)
	);

endmodule

`default_nettype wire

/* design/pfc_front.sv */
// ----------------------------------------------------------------------------
// pfc_front
// Takes message letters, inserts filler and pad, forms pairs for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_front (
	input  wire               clk,
	input  wire               arst_n,
	input  pfc_pkg::cfg_t     cfg,
	input  wire               push,
	input  pfc_pkg::code_t    letter,
	input  wire               message_end,
	input  wire               q_full,
	output logic              q_push,
	output pfc_pkg::pair_job_t q_job
);
	import pfc_pkg::*;

	logic  held_valid_q;
	code_t held_q;
	logic  prev_valid_q;
	code_t prev_q;

	logic      accept;
	logic      enc;
	logic      hv_nx;
	code_t     hl_nx;
	logic      pair0_v;
	pair_job_t job;
	logic      feed_en [3];
	code_t     feed_x  [3];

	assign accept = push && !q_full;
	assign enc    = (cfg.mode == MODE_ENCRYPT);

	// up to three feeds per item: filler, the letter itself, closing pad
	always_comb begin
		hv_nx      = held_valid_q;
		hl_nx      = held_q;
		pair0_v    = 1'b0;
		job        = '0;
		job.last   = message_end;
		feed_en[0] = enc && prev_valid_q && (prev_q == letter);
		feed_x[0]  = cfg.filler;
		feed_en[1] = 1'b1;
		feed_x[1]  = letter;
		feed_en[2] = 1'b0;
		feed_x[2]  = cfg.pad;
		for (int k = 0; k < 3; k++) begin
			if (k == 2)
				feed_en[2] = enc && message_end && hv_nx;
			if (feed_en[k]) begin
				if (hv_nx) begin
					if (!pair0_v) begin
						job.a0  = hl_nx;
						job.b0  = feed_x[k];
						pair0_v = 1'b1;
					end else begin
						job.a1  = hl_nx;
						job.b1  = feed_x[k];
						job.two = 1'b1;
					end
					hv_nx = 1'b0;
				end else begin
					hl_nx = feed_x[k];
					hv_nx = 1'b1;
				end
			end
		end
	end

	assign q_push = accept && pair0_v;
	assign q_job  = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			prev_valid_q <= 1'b0;
		end else if (accept) begin
			held_valid_q <= hv_nx && !message_end;
			if (message_end)
				prev_valid_q <= 1'b0;
			else if (enc)
				prev_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= hl_nx;
			if (enc)
				prev_q <= letter;
		end
	end

endmodule

`default_nettype wire

/* design/pfc_queue.sv */
// ----------------------------------------------------------------------------
// pfc_queue
// Small FIFO of pair jobs between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  pfc_pkg::pair_job_t wr_job,
	output logic               full,
	input  wire                pop,
	output pfc_pkg::pair_job_t rd_job,
	output logic               empty
);
	import pfc_pkg::*;

	pair_job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q;
	logic [QPTR_BITS-1:0]   rd_ptr_q;
	logic [QCNT_BITS-1:0]   count_q;
	logic                   do_push;
	logic                   do_pop;

	assign full    = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_job  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			if (do_push && !do_pop)
				count_q <= count_q + QCNT_BITS'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - QCNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_job;
	end

endmodule

`default_nettype wire

/* design/pfc_back.sv */
// ----------------------------------------------------------------------------
// pfc_back
// Enciphers or deciphers queued pairs, one letter per cycle while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_back (
	input  wire                clk,
	input  wire                arst_n,
	input  pfc_pkg::cfg_t      cfg,
	input  wire                q_empty,
	input  pfc_pkg::pair_job_t q_job,
	output logic               q_pop,
	input  wire                pop,
	output logic               empty,
	output pfc_pkg::code_t     out_letter,
	output logic               out_last
);
	import pfc_pkg::*;

	pair_job_t  job_q;
	logic       job_valid_q;
	logic [1:0] sel_q;          // [1] pair, [0] letter within pair
	logic       out_valid_q;
	code_t      out_letter_q;
	logic       out_last_q;

	code_t      cur_a;
	code_t      cur_b;
	code_pair_t res;
	logic       keep0;
	logic       keep1;
	logic       keep;
	code_t      cur_letter;
	logic       last_pair;
	logic       out_free;
	logic       adv;
	logic       emit;
	logic       job_done;
	logic       load;

	assign cur_a = sel_q[1] ? job_q.a1 : job_q.a0;
	assign cur_b = sel_q[1] ? job_q.b1 : job_q.b0;
	assign res   = pair_cipher(cfg.square, cfg.mode, cur_a, cur_b);

	// decrypt strips filler and pad from the plaintext
	assign keep0 = (cfg.mode == MODE_ENCRYPT) || ((res[0] != cfg.filler) && (res[0] != cfg.pad));
	assign keep1 = (cfg.mode == MODE_ENCRYPT) || ((res[1] != cfg.filler) && (res[1] != cfg.pad));
	assign keep       = sel_q[0] ? keep1 : keep0;
	assign cur_letter = sel_q[0] ? res[1] : res[0];

	assign last_pair = sel_q[1] || !job_q.two;
	assign out_free  = !out_valid_q || pop;
	assign adv       = job_valid_q && (!keep || out_free);
	assign emit      = job_valid_q && keep && out_free;
	assign job_done  = adv && sel_q[0] && last_pair;
	assign load      = !job_valid_q || job_done;
	assign q_pop     = load && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			sel_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				job_valid_q <= !q_empty;
				sel_q       <= '0;
			end else if (adv) begin
				sel_q <= sel_q + 2'd1;
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			job_q <= q_job;
		if (emit) begin
			out_letter_q <= cur_letter;
			out_last_q   <= job_q.last && last_pair && (sel_q[0] || !keep1);
		end
	end

	assign empty      = !out_valid_q;
	assign out_letter = out_letter_q;
	assign out_last   = out_last_q;

endmodule

`default_nettype wire

/* design/pfc_checker.sv */
// ----------------------------------------------------------------------------
// pfc_checker
// Port-level checks of the Playfair cipher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pfc_checker (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         push,
	input  wire                         full,
	input  pfc_pkg::code_t              letter,
	input  wire                         message_end,
	input  wire                         empty,
	input  wire                         pop,
	input  pfc_pkg::code_t              out_letter,
	input  wire                         out_last,
	input  wire                         cfg_we,
	input  wire [pfc_pkg::REG_BITS-1:0] cfg_index,
	input  wire [pfc_pkg::CFG_BITS-1:0] cfg_wdata
);

	// in reset nothing is offered and room is shown
	`ASSERT_CLK_ALWAYS(a_reset_idle, clk, (!arst_n) |-> (empty && !full), "busy flags set in reset")

	// a waiting result holds until taken
	`ASSERT_CLK(a_result_hold, clk, arst_n, (!empty && !pop) |=> (!empty && $stable(out_letter) && $stable(out_last)), "result changed while stalled")

	// the queue only fills up on an accepted item
	`ASSERT_CLK(a_full_on_push, clk, arst_n, $rose(full) |-> $past(push && !full), "full rose without an accepted item")

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (.*);

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming Playfair cipher. A short table of
// directed items and register writes comes first, then random messages over
// random key squares in both modes, with idle and stall patterns on both
// sides and one long result-side hold that backs the block up. Every
// accepted letter goes through a local cipher model; each popped result is
// checked in order against the expected letters that the model queued.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pfc_pkg::*;

	// idle wait before a register write: a queued pair whose letters are all
	// stripped keeps the back end busy after the last visible result
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 80;
	localparam int CYCLE_LIMIT   = 400000;

	typedef enum logic [CODE_BITS-1:0] {
		LTR_A, LTR_B, LTR_C, LTR_D, LTR_E, LTR_F, LTR_G, LTR_H, LTR_I, LTR_J,
		LTR_K, LTR_L, LTR_M, LTR_N, LTR_O, LTR_P, LTR_Q, LTR_R, LTR_S, LTR_T,
		LTR_U, LTR_V, LTR_W, LTR_X, LTR_Y, LTR_Z
	} letter_t;

	// one row of the directed table: either a register write or an item,
	// the item optionally carrying its expected letters
	typedef struct packed {
		logic                      is_write;
		reg_idx_t                  reg_sel;
		logic [CFG_BITS-1:0]       wdata;
		code_t                     letter;
		logic                      msg_end;
		logic                      typed;
		logic [2:0]                n_typed;
		logic [3:0][CODE_BITS-1:0] typed_letters;
	} directed_row_t;

	typedef struct packed {
		code_t letter;
		logic  last;
	} letter_result_t;

	// DUT signals, all known from time zero; reset drops at time zero
	logic                clk;
	logic                arst_n      = 1'b1;
	logic                push        = 1'b0;
	logic                full;
	code_t               letter      = '0;
	logic                message_end = 1'b0;
	logic                empty;
	logic                pop         = 1'b0;
	code_t               out_letter;
	logic                out_last;
	logic                cfg_we      = 1'b0;
	logic [REG_BITS-1:0] cfg_index   = '0;
	logic [CFG_BITS-1:0] cfg_wdata   = '0;

	// cipher model: configuration copy and pairing state
	logic [CFG_BITS-1:0] key_rows [SQUARE_SIDE];
	mode_t               run_mode;
	code_t               filler_code;
	code_t               pad_code;
	code_t               pair_first;
	logic                pair_open;
	code_t               last_plain;
	logic                last_valid;
	code_t               step_letters[$];

	letter_result_t      expected_letters[$];
	letter_result_t      front_item;
	directed_row_t       dir_rows[$];

	int                  send_idle_pct = 0;
	int                  recv_stall_pct = 0;
	int                  hold_reqs = 0;
	int                  hold_seen = 0;
	int                  hold_left = 0;
	int                  errors = 0;
	int                  cycle_count = 0;

	playfair_digraph_cipher uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.letter      (letter),
		.message_end (message_end),
		.empty       (empty),
		.pop         (pop),
		.out_letter  (out_letter),
		.out_last    (out_last),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------- model

	function automatic code_t sq_cell(int r, int c);
		return key_rows[r][c*CODE_BITS +: CODE_BITS];
	endfunction

	// first hit in row-major order; a code missing from the square sits at 0,0
	function automatic void find_cell(code_t v, output int r, output int c);
		bit found;
		found = 1'b0;
		r = 0;
		c = 0;
		for (int i = 0; i < SQUARE_SIDE; i++) begin
			for (int j = 0; j < SQUARE_SIDE; j++) begin
				if (!found && sq_cell(i, j) == v) begin
					found = 1'b1;
					r = i;
					c = j;
				end
			end
		end
	endfunction

	// decrypt strips filler and pad letters from the plaintext
	function automatic void emit_letter(code_t v);
		if (run_mode == MODE_DECRYPT && (v == filler_code || v == pad_code))
			return;
		step_letters.push_back(v);
	endfunction

	function automatic void cipher_pair(code_t a, code_t b);
		int r1, c1, r2, c2, sh;
		sh = (run_mode == MODE_DECRYPT) ? SQUARE_SIDE - 1 : 1;
		if (a == CODE_J)
			a = CODE_I;
		if (b == CODE_J)
			b = CODE_I;
		find_cell(a, r1, c1);
		find_cell(b, r2, c2);
		if (c1 == c2) begin
			// same column wins, identical letters included
			emit_letter(sq_cell((r1 + sh) % SQUARE_SIDE, c1));
			emit_letter(sq_cell((r2 + sh) % SQUARE_SIDE, c2));
		end else if (r1 == r2) begin
			emit_letter(sq_cell(r1, (c1 + sh) % SQUARE_SIDE));
			emit_letter(sq_cell(r2, (c2 + sh) % SQUARE_SIDE));
		end else begin
			emit_letter(sq_cell(r1, c2));
			emit_letter(sq_cell(r2, c1));
		end
	endfunction

	function automatic void feed_letter(code_t v);
		if (pair_open) begin
			cipher_pair(pair_first, v);
			pair_open = 1'b0;
		end else begin
			pair_first = v;
			pair_open  = 1'b1;
		end
	endfunction

	// letters caused by one accepted item, left in step_letters
	function automatic void predict_cipher_letters(code_t v, logic e);
		step_letters.delete();
		if (run_mode == MODE_ENCRYPT) begin
			// doubled letters compare raw codes, before J folds to I
			if (last_valid && last_plain == v)
				feed_letter(filler_code);
			feed_letter(v);
			last_plain = v;
			last_valid = 1'b1;
			if (e && pair_open)
				feed_letter(pad_code);
		end else begin
			// a lone ciphertext letter at the end is simply dropped below
			feed_letter(v);
		end
		if (e) begin
			pair_open  = 1'b0;
			last_valid = 1'b0;
		end
	endfunction

	// ---------------------------------------------------------- table rows

	function automatic directed_row_t cfg_row(reg_idx_t idx, logic [CFG_BITS-1:0] d);
		directed_row_t row;
		row          = '0;
		row.is_write = 1'b1;
		row.reg_sel  = idx;
		row.wdata    = d;
		return row;
	endfunction

	function automatic directed_row_t plain_row(code_t l, logic e);
		directed_row_t row;
		row         = '0;
		row.letter  = l;
		row.msg_end = e;
		return row;
	endfunction

	function automatic directed_row_t known_row(code_t l, logic e, int n,
			code_t x0 = LTR_A, code_t x1 = LTR_A, code_t x2 = LTR_A, code_t x3 = LTR_A);
		directed_row_t row;
		row                  = plain_row(l, e);
		row.typed            = 1'b1;
		row.n_typed          = 3'(n);
		row.typed_letters[0] = x0;
		row.typed_letters[1] = x1;
		row.typed_letters[2] = x2;
		row.typed_letters[3] = x3;
		return row;
	endfunction

	// --------------------------------------------------------------- driving

	// offer one item until taken; push stays up only if another item follows
	// with no gap, so it is never lowered and raised in the same step
	task automatic send_row(directed_row_t row, bit more);
		letter_result_t res;
		int gap;
		push        <= 1'b1;
		letter      <= row.letter;
		message_end <= row.msg_end;
		do @(posedge clk); while (full);
		predict_cipher_letters(row.letter, row.msg_end);
		if (row.typed) begin
			step_letters.delete();
			for (int k = 0; k < row.n_typed; k++)
				step_letters.push_back(row.typed_letters[k]);
		end
		foreach (step_letters[k]) begin
			res.letter = step_letters[k];
			res.last   = row.msg_end && (k == step_letters.size() - 1);
			expected_letters.push_back(res);
		end
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (!more || gap > 0)
			push <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	// registers change only once the block has drained and settled
	task automatic write_reg(reg_idx_t idx, logic [CFG_BITS-1:0] d);
		while (expected_letters.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MODE:   run_mode = mode_t'(d[0]);
			REG_FILLER: filler_code = d[CODE_BITS-1:0];
			REG_PAD:    pad_code = d[CODE_BITS-1:0];
			default:    key_rows[int'(idx)] = d;
		endcase
	endtask

	// shuffled 25-letter square; a damaged one gets duplicate, missing and
	// out-of-alphabet codes. fill/padv below zero pick a random letter
	task automatic write_random_setup(mode_t m, bit damaged, int fill, int padv);
		code_t               cells [SQUARE_SIDE*SQUARE_SIDE];
		code_t               t;
		int                  k, j;
		logic [CFG_BITS-1:0] row_word;
		k = 0;
		for (int v = 0; v < 26; v++) begin
			if (code_t'(v) != CODE_J) begin
				cells[k] = code_t'(v);
				k++;
			end
		end
		for (int i = SQUARE_SIDE*SQUARE_SIDE - 1; i > 0; i--) begin
			j        = $urandom_range(i);
			t        = cells[i];
			cells[i] = cells[j];
			cells[j] = t;
		end
		if (damaged)
			repeat (3) cells[$urandom_range(24)] = code_t'($urandom_range(31));
		for (int r = 0; r < SQUARE_SIDE; r++) begin
			row_word = '0;
			for (int c = 0; c < SQUARE_SIDE; c++)
				row_word[c*CODE_BITS +: CODE_BITS] = cells[r*SQUARE_SIDE + c];
			write_reg(reg_idx_t'(int'(REG_ROW0) + r), row_word);
		end
		write_reg(REG_MODE, CFG_BITS'(m));
		write_reg(REG_FILLER, CFG_BITS'((fill < 0) ? $urandom_range(25) : fill));
		write_reg(REG_PAD, CFG_BITS'((padv < 0) ? $urandom_range(25) : padv));
	endtask

	// random messages of 1..7 letters; doubled letters and I/J are favored,
	// the last item of the batch always closes its message
	task automatic run_messages(int n_items, int idle_pct, int stall_pct);
		int    left, len, roll;
		code_t l, prev;
		logic  e;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		left = n_items;
		prev = '0;
		while (left > 0) begin
			len = $urandom_range(7, 1);
			for (int k = 0; k < len && left > 0; k++) begin
				roll = $urandom_range(99);
				if (k > 0 && roll < 20)
					l = prev;
				else if (roll < 30)
					l = $urandom_range(1) ? code_t'(LTR_I) : code_t'(LTR_J);
				else
					l = code_t'($urandom_range(25));
				left--;
				e = (k == len - 1) || (left == 0);
				send_row(plain_row(l, e), left > 0);
				prev = l;
			end
		end
	endtask

	// ------------------------------------------------------------ result side

	// check at the edge, then pick pop for the next cycle; a long hold
	// requested by the stimulus is counted down here
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_letters.size() == 0) begin
				$error("out_letter: no result expected, got %0d (out_last %0b)",
					out_letter, out_last);
				errors++;
			end else begin
				front_item = expected_letters.pop_front();
				if (out_letter !== front_item.letter) begin
					$error("out_letter: expected %0d, got %0d", front_item.letter, out_letter);
					errors++;
				end
				if (out_last !== front_item.last) begin
					$error("out_last: expected %0b, got %0b", front_item.last, out_last);
					errors++;
				end
			end
		end
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ---------------------------------------------------------------- timeout

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// --------------------------------------------------------------- stimulus

	initial begin
		// reset takes hold before the first clock edge
		arst_n <= 1'b0;
		for (int r = 0; r < SQUARE_SIDE; r++)
			key_rows[r] = SQUARE_RESET[r];
		run_mode    = MODE_ENCRYPT;
		filler_code = FILLER_RESET;
		pad_code    = PAD_RESET;
		pair_first  = '0;
		pair_open   = 1'b0;
		last_plain  = '0;
		last_valid  = 1'b0;

		// reset square is the plain alphabet, rows ABCDE FGHIK LMNOP QRSTU VWXYZ,
		// filler X, pad Q, so the first rows can be worked out by hand
		dir_rows = '{
			known_row(LTR_A, 1'b0, 0),
			known_row(LTR_B, 1'b0, 2, LTR_B, LTR_C),              // same row
			known_row(LTR_A, 1'b0, 0),
			known_row(LTR_F, 1'b0, 2, LTR_F, LTR_L),              // same column
			known_row(LTR_A, 1'b0, 0),
			known_row(LTR_Z, 1'b1, 2, LTR_E, LTR_V),              // corners
			known_row(LTR_U, 1'b0, 0),
			known_row(LTR_Z, 1'b1, 2, LTR_Z, LTR_E),              // column wraps
			known_row(LTR_L, 1'b0, 0),
			// doubled L: filler pair, then pad closes the lone L
			known_row(LTR_L, 1'b1, 4, LTR_N, LTR_V, LTR_Q, LTR_V),
			known_row(LTR_I, 1'b0, 0),
			known_row(LTR_J, 1'b1, 2, LTR_O, LTR_O),              // I,J: no filler
			known_row(LTR_Z, 1'b1, 2, LTR_V, LTR_U),              // one-letter message
			cfg_row(REG_FILLER, CFG_BITS'(LTR_A)),
			cfg_row(REG_PAD, CFG_BITS'(LTR_Z)),
			plain_row(LTR_B, 1'b0),
			plain_row(LTR_B, 1'b1),
			cfg_row(REG_MODE, CFG_BITS'(MODE_DECRYPT)),
			plain_row(LTR_C, 1'b0),
			plain_row(LTR_B, 1'b0),                                // filler stripped
			plain_row(LTR_E, 1'b0),
			plain_row(LTR_W, 1'b1),                                // pad stripped
			plain_row(LTR_A, 1'b1),                                // odd letter dropped
			plain_row(LTR_D, 1'b0),
			// mode flips while D is held
			cfg_row(REG_MODE, CFG_BITS'(MODE_ENCRYPT)),
			plain_row(LTR_G, 1'b1),
			// row 0 all code 31, row 1 all A: missing letters and duplicates
			cfg_row(REG_ROW0, {CFG_BITS{1'b1}}),
			cfg_row(REG_ROW1, '0),
			plain_row(LTR_A, 1'b0),
			plain_row(LTR_B, 1'b1)
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < dir_rows.size(); i++) begin
			if (dir_rows[i].is_write)
				write_reg(dir_rows[i].reg_sel, dir_rows[i].wdata);
			else
				send_row(dir_rows[i], i + 1 < dir_rows.size() && !dir_rows[i+1].is_write);
		end

		// random phases, each over a fresh setup
		write_random_setup(MODE_ENCRYPT, 1'b0, -1, -1);
		run_messages(16, 0, 0);
		write_random_setup(MODE_DECRYPT, 1'b0, -1, -1);
		run_messages(16, 72, 0);
		write_random_setup(MODE_ENCRYPT, 1'b1, 25, 0);
		run_messages(16, 0, 72);
		write_random_setup(MODE_DECRYPT, 1'b1, -1, -1);
		run_messages(16, 28, 28);

		// back-pressure: result side holds off while items keep coming
		write_random_setup(MODE_ENCRYPT, 1'b0, -1, -1);
		hold_reqs++;
		run_messages(20, 0, 0);

		recv_stall_pct = 0;
		while (expected_letters.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
